>>> rtl/rmg_pkg.sv
// Shared constants, types and helper functions of the region mean gradient grid.
package rmg_pkg;

  // Grid geometry and value format
  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 16;
  localparam int VALUE_BITS = 24;

  // Fixed field widths of the item ports
  localparam int FIELD_W    = 5;
  localparam int KIND_W     = 2;
  localparam int GRAD_W     = 24;
  localparam int FRAC_EXTRA = 16;

  // Cell addressing: {row, col}
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;

  // Datapath widths
  localparam int SUM_W   = VALUE_BITS + 2;
  localparam int AVG_W   = SUM_W + FRAC_EXTRA;
  localparam int PT_W    = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int TOTAL_W = AVG_W + PT_W;
  localparam int DCNT_W  = $clog2(TOTAL_W);

  // Reciprocal of three: floor(x / 3) = (x * RCP_K) >> RCP_S for x < 2^SUM_W
  localparam int RCP_S = SUM_W + 2;
  localparam int RCP_W = RCP_S;
  localparam logic [RCP_W-1:0] RCP_K = RCP_W'(((longint'(1) << RCP_S) + 2) / 3);

  // Fractional part of (r << FRAC_EXTRA) / 3 for remainders one and two
  localparam logic [AVG_W-1:0] R3_ONE = AVG_W'((longint'(1) << FRAC_EXTRA) / 3);
  localparam logic [AVG_W-1:0] R3_TWO = AVG_W'((longint'(2) << FRAC_EXTRA) / 3);

  localparam logic [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};

  // Per-cell phases: reads issue in phases 0..4, data is consumed in phases 1..5
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_CENTER = 3'd0;
  localparam logic [PH_W-1:0] PH_UP     = 3'd1;
  localparam logic [PH_W-1:0] PH_DOWN   = 3'd2;
  localparam logic [PH_W-1:0] PH_LEFT   = 3'd3;
  localparam logic [PH_W-1:0] PH_RIGHT  = 3'd4;
  localparam logic [PH_W-1:0] PH_LAST   = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_RESIZE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;
    logic clr_grad;
    logic wr;
    logic rs_start;
    logic sweep;
    logic commit;
    logic q_start;
    logic q_step;
    logic div_start;
    logic grad_load;
    logic load_out;
    logic res_err;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    kind_e kind;
    logic  wr_ok;
    logic  rs_ok;
    logic  q_ok;
    logic  sw_last;
    logic  ph_last;
    logic  cell_last;
    logic  pipe_busy;
    logic  points_zero;
    logic  div_done;
  } st_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [FIELD_W-1:0] r,
                                                input logic [FIELD_W-1:0] c);
    addr_of = {ROW_W'(r), COL_W'(c)};
  endfunction

endpackage

>>> rtl/rmg_div.sv
// Restoring divider, one quotient bit per cycle, for the final region mean.
module rmg_div import rmg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [TOTAL_W-1:0] dividend_i,
  input  logic [PT_W-1:0]    divisor_i,
  output logic               done_o,
  output logic [TOTAL_W-1:0] quotient_o
);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [PT_W-1:0]   rem_q;
  logic [TOTAL_W-1:0] quo_q;
  logic [PT_W-1:0]   div_q;
  logic [PT_W:0]     shift;
  logic              ge;

  // Shift in the next dividend bit and try a subtract
  assign shift = {rem_q, quo_q[TOTAL_W-1]};
  assign ge    = shift >= {1'b0, div_q};

  // Advance the control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(TOTAL_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DCNT_W'(1);
        if (cnt_q == '0) busy_q <= 1'b0;
      end
    end
  end

  // Hold the operands and the partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? PT_W'(shift - {1'b0, div_q}) : PT_W'(shift);
      quo_q <= {quo_q[TOTAL_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/rmg_datapath.sv
// Datapath: captured item, grid memory, region walk, per-cell average and mean.
module rmg_datapath import rmg_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  output st_t                          st_o,
  input  logic [KIND_W-1:0]            kind_i,
  input  logic [FIELD_W-1:0]           row_first_i,
  input  logic [FIELD_W-1:0]           col_first_i,
  input  logic [FIELD_W-1:0]           row_last_i,
  input  logic [FIELD_W-1:0]           col_last_i,
  input  logic [FIELD_W-1:0]           new_rows_i,
  input  logic [FIELD_W-1:0]           new_cols_i,
  input  logic signed [GRAD_W-1:0]     cell_value_i,
  output logic                         status_o,
  output logic signed [GRAD_W-1:0]     gradient_o
);

  // Captured item
  logic [KIND_W-1:0]     kind_q;
  logic [FIELD_W-1:0]    r0_q, c0_q, r1_q, c1_q, nr_q, nc_q;
  logic [VALUE_BITS-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q <= kind_i;
      r0_q   <= row_first_i;
      c0_q   <= col_first_i;
      r1_q   <= row_last_i;
      c1_q   <= col_last_i;
      nr_q   <= new_rows_i;
      nc_q   <= new_cols_i;
      val_q  <= VALUE_BITS'(cell_value_i);
    end
  end

  // Grid size and sweep bounds
  logic [FIELD_W-1:0] rows_q, cols_q, keep_r_q, keep_c_q;
  logic [ADDR_W-1:0]  sw_q;
  logic               sw_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= '0;
      cols_q   <= '0;
      keep_r_q <= '0;
      keep_c_q <= '0;
      sw_q     <= '0;
    end else begin
      if (cmd_i.rs_start) begin
        keep_r_q <= (rows_q < nr_q) ? rows_q : nr_q;
        keep_c_q <= (cols_q < nc_q) ? cols_q : nc_q;
        sw_q     <= '0;
      end else if (cmd_i.sweep) begin
        sw_q <= sw_q + ADDR_W'(1);
      end
      if (cmd_i.commit) begin
        rows_q <= nr_q;
        cols_q <= nc_q;
      end
    end
  end

  assign sw_zero = (int'(sw_q[ADDR_W-1:COL_W]) >= int'(keep_r_q)) ||
                   (int'(sw_q[COL_W-1:0]) >= int'(keep_c_q));

  // Region walk counters
  logic [FIELD_W-1:0] i_q, j_q;
  logic [PH_W-1:0]    ph_q;
  logic               ph_last, cell_last;

  assign ph_last   = ph_q == PH_LAST;
  assign cell_last = (i_q == r1_q) && (j_q == c1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      i_q  <= r0_q;
      j_q  <= c0_q;
      ph_q <= PH_CENTER;
    end else if (cmd_i.q_step) begin
      if (ph_last) begin
        ph_q <= PH_CENTER;
        if (j_q == c1_q) begin
          j_q <= c0_q;
          i_q <= i_q + FIELD_W'(1);
        end else begin
          j_q <= j_q + FIELD_W'(1);
        end
      end else begin
        ph_q <= ph_q + PH_W'(1);
      end
    end
  end

  // Neighbor existence of the current cell: up, down, left, right
  logic [3:0] ex;
  assign ex[0] = i_q != '0;
  assign ex[1] = ({1'b0, i_q} + (FIELD_W+1)'(1)) < {1'b0, rows_q};
  assign ex[2] = j_q != '0;
  assign ex[3] = ({1'b0, j_q} + (FIELD_W+1)'(1)) < {1'b0, cols_q};

  // Select the read address for this phase
  logic [ADDR_W-1:0] raddr;
  always_comb begin
    case (ph_q)
      PH_CENTER: raddr = addr_of(i_q, j_q);
      PH_UP:     raddr = addr_of(i_q - FIELD_W'(1), j_q);
      PH_DOWN:   raddr = addr_of(i_q + FIELD_W'(1), j_q);
      PH_LEFT:   raddr = addr_of(i_q, j_q - FIELD_W'(1));
      default:   raddr = addr_of(i_q, j_q + FIELD_W'(1));
    endcase
  end

  // Grid memory: one write port, one registered read port
  logic [VALUE_BITS-1:0] grid_q [DEPTH];
  logic [VALUE_BITS-1:0] rdata_q;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [VALUE_BITS-1:0] wdata;

  assign we    = (cmd_i.sweep && sw_zero) || cmd_i.wr;
  assign waddr = cmd_i.sweep ? sw_q : addr_of(r0_q, c0_q);
  assign wdata = cmd_i.sweep ? '0 : val_q;

  always_ff @(posedge clk_i) begin
    if (we) grid_q[waddr] <= wdata;
    rdata_q <= grid_q[raddr];
  end

  // Accumulate absolute differences of the existing neighbors
  logic [VALUE_BITS-1:0]   center_q;
  logic [SUM_W-1:0]        sum_q, sum_nx;
  logic signed [VALUE_BITS:0] dif;
  logic [VALUE_BITS-1:0]   mag;
  logic                    ex_cur;
  logic [2:0]              n_cnt;

  assign dif = $signed({rdata_q[VALUE_BITS-1], rdata_q}) -
               $signed({center_q[VALUE_BITS-1], center_q});
  assign mag = dif[VALUE_BITS] ? VALUE_BITS'(-dif) : VALUE_BITS'(dif);

  always_comb begin
    case (ph_q)
      PH_DOWN:  ex_cur = ex[0];
      PH_LEFT:  ex_cur = ex[1];
      PH_RIGHT: ex_cur = ex[2];
      PH_LAST:  ex_cur = ex[3];
      default:  ex_cur = 1'b0;
    endcase
  end

  assign sum_nx = sum_q + (ex_cur ? SUM_W'(mag) : '0);
  assign n_cnt  = 3'({2'b0, ex[0]} + {2'b0, ex[1]} + {2'b0, ex[2]} + {2'b0, ex[3]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_step) begin
      if (ph_q == PH_UP) begin
        center_q <= rdata_q;
        sum_q    <= '0;
      end else if (ph_q != PH_CENTER) begin
        sum_q <= sum_nx;
      end
    end
  end

  // Per-cell average pipeline: capture, multiply, select, accumulate
  logic                     s1_v, s2_v, s3_v;
  logic [SUM_W-1:0]         s1_sum, s2_sum;
  logic [2:0]               s1_n, s2_n;
  logic [SUM_W+RCP_W-1:0]   s2_prod;
  logic [AVG_W-1:0]         s3_avg, avg;
  logic [SUM_W-1:0]         q3, r3_full;
  logic [TOTAL_W-1:0]       total_q;
  logic [PT_W-1:0]          points_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= cmd_i.q_step && ph_last && (n_cnt != 3'd0);
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  assign q3      = SUM_W'(s2_prod >> RCP_S);
  assign r3_full = s2_sum - q3 - (q3 << 1);

  always_comb begin
    case (s2_n)
      3'd1:    avg = AVG_W'(s2_sum) << FRAC_EXTRA;
      3'd2:    avg = AVG_W'(s2_sum) << (FRAC_EXTRA - 1);
      3'd3: begin
        case (r3_full[1:0])
          2'd1:    avg = (AVG_W'(q3) << FRAC_EXTRA) + R3_ONE;
          2'd2:    avg = (AVG_W'(q3) << FRAC_EXTRA) + R3_TWO;
          default: avg = AVG_W'(q3) << FRAC_EXTRA;
        endcase
      end
      default: avg = AVG_W'(s2_sum) << (FRAC_EXTRA - 2);
    endcase
  end

  always_ff @(posedge clk_i) begin
    s1_sum  <= sum_nx;
    s1_n    <= n_cnt;
    s2_prod <= (SUM_W+RCP_W)'(s1_sum) * (SUM_W+RCP_W)'(RCP_K);
    s2_sum  <= s1_sum;
    s2_n    <= s1_n;
    s3_avg  <= avg;
    if (cmd_i.q_start) begin
      total_q  <= '0;
      points_q <= '0;
    end else if (s3_v) begin
      total_q  <= total_q + TOTAL_W'(s3_avg);
      points_q <= points_q + PT_W'(1);
    end
  end

  // Final mean over the region
  logic               div_done;
  logic [TOTAL_W-1:0] quo;
  logic [TOTAL_W-1:0] quo_hi;

  rmg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (total_q),
    .divisor_i  (points_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign quo_hi = quo >> FRAC_EXTRA;

  // Saturate the mean and hold the result
  logic [GRAD_W-1:0] grad_q;
  logic              out_status_q;
  logic [GRAD_W-1:0] out_grad_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_grad) begin
      grad_q <= '0;
    end else if (cmd_i.grad_load) begin
      grad_q <= (quo_hi > TOTAL_W'(GRAD_MAX)) ? GRAD_MAX : GRAD_W'(quo_hi);
    end
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.res_err;
      out_grad_q   <= grad_q;
    end
  end

  assign status_o   = out_status_q;
  assign gradient_o = $signed(out_grad_q);

  // Status to the controller
  assign st_o.kind        = kind_e'(kind_q);
  assign st_o.wr_ok       = (r0_q < rows_q) && (c0_q < cols_q) &&
                            (int'(r0_q) < MAX_ROWS) && (int'(c0_q) < MAX_COLS);
  assign st_o.rs_ok       = (nr_q != '0) && (nc_q != '0) &&
                            (int'(nr_q) <= MAX_ROWS) && (int'(nc_q) <= MAX_COLS);
  assign st_o.q_ok        = (r1_q < rows_q) && (c1_q < cols_q) &&
                            (r0_q <= r1_q) && (c0_q <= c1_q);
  assign st_o.sw_last     = sw_q == '1;
  assign st_o.ph_last     = ph_last;
  assign st_o.cell_last   = cell_last;
  assign st_o.pipe_busy   = s1_v || s2_v || s3_v;
  assign st_o.points_zero = points_q == '0;
  assign st_o.div_done    = div_done;

endmodule

>>> rtl/rmg_ctrl.sv
// Controller state machine: item sequencing, grid sweep, query walk and result handoff.
module rmg_ctrl import rmg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  st_t  st_i,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_RST_CLR = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_DECODE  = 8'b0000_0100,
    S_SWEEP   = 8'b0000_1000,
    S_QRUN    = 8'b0001_0000,
    S_QDRAIN  = 8'b0010_0000,
    S_QDIV    = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   err_q, err_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    cmd_o   = '0;
    cmd_o.res_err = err_q;
    case (state_q)
      S_RST_CLR: begin
        cmd_o.sweep = 1'b1;
        if (st_i.sw_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.clr_grad = 1'b1;
        err_d          = 1'b1;
        state_d        = S_RESP;
        case (st_i.kind)
          KIND_WRITE: begin
            if (st_i.wr_ok) begin
              cmd_o.wr = 1'b1;
              err_d    = 1'b0;
            end
          end
          KIND_RESIZE: begin
            if (st_i.rs_ok) begin
              cmd_o.rs_start = 1'b1;
              err_d          = 1'b0;
              state_d        = S_SWEEP;
            end
          end
          KIND_QUERY: begin
            if (st_i.q_ok) begin
              cmd_o.q_start = 1'b1;
              err_d         = 1'b0;
              state_d       = S_QRUN;
            end
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (st_i.sw_last) begin
          cmd_o.commit = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_QRUN: begin
        cmd_o.q_step = 1'b1;
        if (st_i.ph_last && st_i.cell_last) state_d = S_QDRAIN;
      end
      S_QDRAIN: begin
        if (!st_i.pipe_busy) begin
          if (st_i.points_zero) begin
            state_d = S_RESP;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_QDIV;
          end
        end
      end
      S_QDIV: begin
        if (st_i.div_done) begin
          cmd_o.grad_load = 1'b1;
          state_d         = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Advance state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RST_CLR;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
      if (cmd_o.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // The divider only finishes while the controller waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_i.div_done |-> state_q == S_QDIV)
    else $error("divider done outside wait state");

  // A drained query with points goes on to the divide
  a_drain_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QDRAIN && !st_i.pipe_busy && !st_i.points_zero) |=> state_q == S_QDIV)
    else $error("drained query did not start the divide");

endmodule

>>> rtl/region_mean_gradient_grid.sv
// Top level of the region mean gradient grid: controller plus datapath.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+---------------------------------------------
//  in      | in_valid_i | in_stall_o  | kind, row/col first/last, new_rows/cols, cell_value
//  out     | out_valid_o| out_stall_i | status, gradient
//
//  A resize sweeps every grid entry, one per cycle, zeroing those outside the kept
//  rows and columns through the single memory write port.
//  A query makes five reads per region cell on the one read port, then drains the
//  average pipeline and runs the bit-serial division.
//  After reset a clearing pass zeroes the grid; no item is taken meanwhile.
//  One item is in work at a time; the next is taken while the last result waits.
module region_mean_gradient_grid import rmg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic [FIELD_W-1:0]       row_first_i,
  input  logic [FIELD_W-1:0]       col_first_i,
  input  logic [FIELD_W-1:0]       row_last_i,
  input  logic [FIELD_W-1:0]       col_last_i,
  input  logic [FIELD_W-1:0]       new_rows_i,
  input  logic [FIELD_W-1:0]       new_cols_i,
  input  logic signed [GRAD_W-1:0] cell_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     status_o,
  output logic signed [GRAD_W-1:0] gradient_o
);

  cmd_t cmd;
  st_t  st;

  rmg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  rmg_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .kind_i       (kind_i),
    .row_first_i  (row_first_i),
    .col_first_i  (col_first_i),
    .row_last_i   (row_last_i),
    .col_last_i   (col_last_i),
    .new_rows_i   (new_rows_i),
    .new_cols_i   (new_cols_i),
    .cell_value_i (cell_value_i),
    .status_o     (status_o),
    .gradient_o   (gradient_o)
  );

endmodule
